### design/hbwf_pkg.sv
// Package for the box wall force block: controller states, command and status structs,
// wall codes and configuration register indexes.
// No dependencies.
package hbwf_pkg;

    localparam logic [2:0] NO_WALL = 3'd6;

    localparam logic [2:0] REG_CX   = 3'd0;
    localparam logic [2:0] REG_CY   = 3'd1;
    localparam logic [2:0] REG_CZ   = 3'd2;
    localparam logic [2:0] REG_SX   = 3'd3;
    localparam logic [2:0] REG_SY   = 3'd4;
    localparam logic [2:0] REG_SZ   = 3'd5;
    localparam logic [2:0] REG_GAIN = 3'd6;
    localparam logic [2:0] REG_RAD  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_DEPTH,
        ST_SQRT,
        ST_FACE,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       dist_step;
        logic       depth_start;
        logic       sqrt_step;
        logic       face_calc;
        logic       mul_calc;
        logic       out_load;
        logic       depth_fresh;
    } t_cmd;

    typedef struct packed {
        logic       dist_done;
        logic       sqrt_done;
        logic       need_sqrt;
    } t_status;

endpackage

### design/hbwf_ctrl.sv
// Controller state machine for the box wall force block.
// Depends on hbwf_pkg.
module hbwf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_out_free,
    input  hbwf_pkg::t_status  i_status,
    output hbwf_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    hbwf_pkg::t_state r_state, n_state;
    logic r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbwf_pkg::ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        unique case (r_state)
            hbwf_pkg::ST_IDLE: if (i_in_fire) begin
                n_state = hbwf_pkg::ST_DIST;
                n_pass  = 1'b0;
            end
            hbwf_pkg::ST_DIST: if (i_status.dist_done) n_state = hbwf_pkg::ST_DEPTH;
            hbwf_pkg::ST_DEPTH: n_state = i_status.need_sqrt ? hbwf_pkg::ST_SQRT
                                                             : hbwf_pkg::ST_FACE;
            hbwf_pkg::ST_SQRT: if (i_status.sqrt_done) n_state = hbwf_pkg::ST_FACE;
            hbwf_pkg::ST_FACE: begin
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = hbwf_pkg::ST_DEPTH;
                end else begin
                    n_state = hbwf_pkg::ST_MUL;
                end
            end
            hbwf_pkg::ST_MUL: n_state = hbwf_pkg::ST_OUT;
            hbwf_pkg::ST_OUT: if (i_out_free) n_state = hbwf_pkg::ST_IDLE;
            default: n_state = hbwf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.depth_fresh = !r_pass;
        unique case (r_state)
            hbwf_pkg::ST_IDLE:  o_cmd.load = i_in_fire;
            hbwf_pkg::ST_DIST:  o_cmd.dist_step = 1'b1;
            hbwf_pkg::ST_DEPTH: o_cmd.depth_start = 1'b1;
            hbwf_pkg::ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            hbwf_pkg::ST_FACE:  o_cmd.face_calc = 1'b1;
            hbwf_pkg::ST_MUL:   o_cmd.mul_calc = 1'b1;
            hbwf_pkg::ST_OUT:   o_cmd.out_load = i_out_free;
            default: ;
        endcase
    end

    assign o_busy = (r_state != hbwf_pkg::ST_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == hbwf_pkg::ST_IDLE) else $error("load outside idle");
    a_out_next_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == hbwf_pkg::ST_IDLE) else $error("bad out");
    a_mul_after_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hbwf_pkg::ST_MUL |-> $past(r_state) == hbwf_pkg::ST_FACE)
        else $error("mul order");
endmodule

### design/hbwf_dp.sv
// Datapath for the box wall force block: wall distance scan, gap and sqrt unit,
// depth, force multiply and saturation.
// Depends on hbwf_pkg.
module hbwf_dp #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hbwf_pkg::t_cmd        i_cmd,
    output hbwf_pkg::t_status     o_status,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic signed [31:0]    i_corner [3],
    input  logic        [30:0]    i_size [3],
    input  logic        [30:0]    i_gain,
    input  logic        [30:0]    i_radius,
    output logic signed [31:0]    o_force_x,
    output logic signed [31:0]    o_force_y,
    output logic signed [31:0]    o_force_z,
    output logic        [2:0]     o_wall
);
    localparam int SAT_BITS = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

    logic signed [33:0] r_p [3];
    logic signed [33:0] w_lo [3], w_hi [3];
    logic [2:0] r_w, r_best, r_ent, r_cur;
    logic [1:0] r_k;
    logic [69:0] r_sum, r_bestd;
    logic [62:0] r_x, r_root, r_bit;
    logic [31:0] r_s;
    logic signed [34:0] r_depth;
    logic [5:0] r_it;
    logic [2:0] r_fresh;
    logic [34:0] r_mag;
    logic [65:0] r_prod;

    always_comb begin
        w_lo[0] = 34'(i_corner[0]); w_lo[1] = 34'(i_corner[1]); w_lo[2] = 34'(i_corner[2]);
        for (int i = 0; i < 3; i++) w_hi[i] = w_lo[i] + 34'($signed({1'b0, i_size[i]}));
    end

    // distance scan: one (wall, axis) term per cycle
    logic [1:0] d_n;
    logic signed [35:0] d_c2, d_diff;
    logic [34:0] d_m;
    logic [69:0] d_sum;
    always_comb begin
        d_n = r_w[2:1];
        if (r_k == d_n) d_c2 = r_w[0] ? 36'(w_hi[r_k]) <<< 1 : 36'(w_lo[r_k]) <<< 1;
        else d_c2 = 36'(w_lo[r_k]) + 36'(w_hi[r_k]);
        d_diff = d_c2 - (36'(r_p[r_k]) <<< 1);
        d_m = d_diff[35] ? 35'(-d_diff) : 35'(d_diff);
        d_sum = r_sum + 70'(d_m) * 70'(d_m);
    end
    assign o_status.dist_done = (r_w == 3'd6);

    // gaps for wall under test
    logic [2:0] g_wall;
    logic [1:0] g_n, g_h, g_v;
    logic [33:0] g_a, g_b;
    logic [67:0] g_t;
    function automatic logic [33:0] gap(input logic signed [33:0] p, input logic signed [33:0] lo,
                                       input logic signed [33:0] hi);
        if (p < lo) return 34'(lo - p);
        if (p > hi) return 34'(p - hi);
        return '0;
    endfunction
    always_comb begin
        g_wall = i_cmd.depth_fresh ? r_best : r_ent;
        g_n = g_wall[2:1];
        g_h = (g_n == 2'd0) ? 2'd1 : 2'd0;
        g_v = (g_n == 2'd2) ? 2'd1 : 2'd2;
        g_a = gap(r_p[g_h], w_lo[g_h], w_hi[g_h]);
        g_b = gap(r_p[g_v], w_lo[g_v], w_hi[g_v]);
        g_t = 68'(i_radius) * 68'(i_radius) - 68'(g_a) * 68'(g_a) - 68'(g_b) * 68'(g_b);
    end
    assign o_status.need_sqrt = (g_a < 34'(i_radius)) && (g_b < 34'(i_radius))
                                && !g_t[67] && (g_t != '0);
    assign o_status.sqrt_done = (r_it == 6'd31);

    logic [62:0] q_sum;
    assign q_sum = r_root + r_bit;

    // face depth for wall r_cur with reach r_s
    logic signed [35:0] f_depth;
    always_comb begin
        if (r_cur[0]) f_depth = 36'(w_hi[r_cur[2:1]]) + 36'(r_s) - 36'(r_p[r_cur[2:1]]);
        else          f_depth = 36'(r_p[r_cur[2:1]]) + 36'(r_s) - 36'(w_lo[r_cur[2:1]]);
    end

    logic [31:0] m_lim, m_q;
    logic m_neg;
    always_comb begin
        m_neg = !r_cur[0];
        m_lim = 32'((64'd1 << (SAT_BITS - 1)) - (m_neg ? 64'd0 : 64'd1));
        if (r_prod[65:48] != '0 || r_prod[47:16] > m_lim) m_q = m_lim;
        else m_q = r_prod[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= hbwf_pkg::NO_WALL;
        end else if (i_cmd.face_calc && !i_cmd.depth_fresh) begin
            r_ent <= r_cur;
        end else if (i_cmd.face_calc) begin
            r_ent <= (f_depth > 0) ? ((r_ent == hbwf_pkg::NO_WALL) ? r_cur : r_ent)
                                   : hbwf_pkg::NO_WALL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p[0] <= 34'(i_pos_x); r_p[1] <= 34'(i_pos_y); r_p[2] <= 34'(i_pos_z);
            r_w <= '0; r_k <= '0; r_sum <= '0; r_best <= '0; r_bestd <= '0;
        end
        if (i_cmd.dist_step) begin
            if (r_k == 2'd2) begin
                if (r_w == 3'd0 || d_sum < r_bestd) begin
                    r_best <= r_w; r_bestd <= d_sum;
                end
                r_sum <= '0; r_k <= '0; r_w <= r_w + 3'd1;
            end else begin
                r_sum <= d_sum; r_k <= r_k + 2'd1;
            end
        end
        if (i_cmd.depth_start) begin
            r_cur <= i_cmd.depth_fresh ? r_best : r_ent;
            r_x <= 63'(g_t); r_root <= '0; r_bit <= 63'(1) << 62; r_it <= '0;
            r_s <= ((g_a == '0) && (g_b == '0)) ? 32'(i_radius) : '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_x >= q_sum) begin
                r_x <= r_x - q_sum; r_root <= (r_root >> 1) + r_bit;
            end else r_root <= r_root >> 1;
            r_bit <= r_bit >> 2;
            r_it <= r_it + 6'd1;
            if (r_it == 6'd31) begin
                r_s <= (r_x >= q_sum) ? 32'((r_root >> 1) + r_bit) : 32'(r_root >> 1);
            end
        end
        if (i_cmd.face_calc) begin
            r_depth <= 35'(f_depth);
            if (i_cmd.depth_fresh) begin
                r_fresh <= (f_depth > 0) ? r_cur : hbwf_pkg::NO_WALL;
            end
        end
        if (i_cmd.mul_calc) begin
            r_mag <= r_depth[34] ? '0 : 35'(r_depth);
            r_prod <= 66'(r_depth[34] ? 35'd0 : 35'(r_depth)) * 66'(i_gain);
        end
    end

    // final wall and force register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_force_x <= '0; o_force_y <= '0; o_force_z <= '0;
            o_wall <= r_ent;
            if (r_ent != hbwf_pkg::NO_WALL && r_mag != '0) begin
                unique case (r_cur[2:1])
                    2'd0: o_force_x <= m_neg ? -m_q : m_q;
                    2'd1: o_force_y <= m_neg ? -m_q : m_q;
                    default: o_force_z <= m_neg ? -m_q : m_q;
                endcase
            end
        end
    end

    logic unused_ok;
    assign unused_ok = ^{r_fresh};
endmodule

### design/haptic_box_wall_force.sv
// Box wall penalty force: each position transaction gives one force transaction.
// The block takes no new position until the result for the last one is loaded into the
// output register: a wall distance scan of one term per cycle, then two depth passes
// (fresh wall, then entered wall), each with the 32-step sqrt when it is needed, then
// multiply and output. A result held by m_axis_tready stalls the next position in the
// output stage. Config must be written only while idle; the block does not enforce this.
// Depends on hbwf_pkg, hbwf_ctrl, hbwf_dp.
module haptic_box_wall_force #(
    parameter int COORD_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // force_x, force_y, force_z, contact_wall, pad
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    logic signed [31:0] r_corner [3];
    logic [30:0] r_size [3];
    logic [30:0] r_gain, r_radius;
    hbwf_pkg::t_cmd w_cmd;
    hbwf_pkg::t_status w_status;
    logic w_busy, r_oval;
    logic signed [31:0] w_fx, w_fy, w_fz;
    logic [2:0] w_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_corner[i] <= '0; r_size[i] <= '0;
            end
            r_gain <= '0; r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbwf_pkg::REG_CX:   r_corner[0] <= i_cfg_data;
                hbwf_pkg::REG_CY:   r_corner[1] <= i_cfg_data;
                hbwf_pkg::REG_CZ:   r_corner[2] <= i_cfg_data;
                hbwf_pkg::REG_SX:   r_size[0] <= i_cfg_data[30:0];
                hbwf_pkg::REG_SY:   r_size[1] <= i_cfg_data[30:0];
                hbwf_pkg::REG_SZ:   r_size[2] <= i_cfg_data[30:0];
                hbwf_pkg::REG_GAIN: r_gain <= i_cfg_data[30:0];
                hbwf_pkg::REG_RAD:  r_radius <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    logic w_out_free;
    assign w_out_free = !r_oval || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_oval <= 1'b0;
        else if (w_cmd.out_load) r_oval <= 1'b1;
        else if (m_axis_tready) r_oval <= 1'b0;
    end

    hbwf_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_free(w_out_free),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    hbwf_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_pos_x(s_axis_tdata[31:0]), .i_pos_y(s_axis_tdata[63:32]),
        .i_pos_z(s_axis_tdata[95:64]),
        .i_corner(r_corner), .i_size(r_size), .i_gain(r_gain), .i_radius(r_radius),
        .o_force_x(w_fx), .o_force_y(w_fy), .o_force_z(w_fz), .o_wall(w_wall)
    );

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = {5'd0, w_wall, w_fz, w_fy, w_fx};
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for haptic_box_wall_force: drives cursor positions and box settings,
// predicts forces and contact wall, and checks every force transaction in order.
// Depends on hbwf_pkg and the haptic_box_wall_force RTL.
module tb_top;

    localparam logic [2:0] REG_CX = hbwf_pkg::REG_CX, REG_CY = hbwf_pkg::REG_CY,
        REG_CZ = hbwf_pkg::REG_CZ, REG_SX = hbwf_pkg::REG_SX, REG_SY = hbwf_pkg::REG_SY,
        REG_SZ = hbwf_pkg::REG_SZ, REG_GAIN = hbwf_pkg::REG_GAIN, REG_RAD = hbwf_pkg::REG_RAD;

    typedef struct packed {
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
        logic [2:0]  wall;
    } t_force;

    class force_board;
        longint signed lo[3], hi[3];
        logic [31:0] cfg[8];
        logic [2:0] entered;
        t_force pending[$];
        int errors;

        function void clear();
            for (int i = 0; i < 8; i++) cfg[i] = '0;
            entered = hbwf_pkg::NO_WALL;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            cfg[idx] = (idx < REG_SX) ? val : {1'b0, val[30:0]};
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint signed gap(longint signed p, longint signed l, longint signed h);
            if (p < l) return l - p;
            if (p > h) return p - h;
            return 0;
        endfunction

        function longint signed depth(longint signed p[3], int w);
            int n, h, v;
            longint signed r, s, a, b, t;
            n = w / 2;
            h = (n == 0) ? 1 : 0;
            v = (n == 2) ? 1 : 2;
            r = cfg[REG_RAD];
            s = 0;
            a = gap(p[h], lo[h], hi[h]);
            b = gap(p[v], lo[v], hi[v]);
            if (a < r && b < r) begin
                t = r * r - a * a - b * b;
                if (t > 0) s = root(t);
            end
            if (w % 2) return hi[n] + s - p[n];
            return p[n] + s - lo[n];
        endfunction

        function void note_position(logic [95:0] d);
            longint signed p[3], dd, c2, df;
            logic [127:0] sum, best;
            logic [127:0] m;
            logic [127:0] pr;
            logic [63:0] q, lim;
            int fresh, n;
            t_force f;
            for (int k = 0; k < 3; k++) begin
                p[k] = longint'($signed(d[32*k +: 32]));
                lo[k] = longint'($signed(cfg[k]));
                hi[k] = lo[k] + longint'(cfg[3 + k]);
            end
            fresh = 0;
            best = '0;
            for (int w = 0; w < 6; w++) begin
                sum = '0;
                for (int k = 0; k < 3; k++) begin
                    if (k == w / 2) c2 = (w % 2) ? 2 * hi[k] : 2 * lo[k];
                    else c2 = lo[k] + hi[k];
                    df = c2 - 2 * p[k];
                    m = (df < 0) ? 128'(-df) : 128'(df);
                    sum += m * m;
                end
                if (w == 0 || sum < best) begin
                    fresh = w;
                    best = sum;
                end
            end
            if (depth(p, fresh) <= 0) fresh = hbwf_pkg::NO_WALL;
            if (entered == hbwf_pkg::NO_WALL || fresh == hbwf_pkg::NO_WALL) entered = 3'(fresh);
            f = '0;
            f.wall = entered;
            if (entered != hbwf_pkg::NO_WALL) begin
                dd = depth(p, entered);
                if (dd > 0) begin
                    n = entered / 2;
                    pr = 128'(dd) * 128'(cfg[REG_GAIN]);
                    lim = entered[0] ? 64'h7FFF_FFFF : 64'h8000_0000;
                    q = pr[79:16];
                    if (pr[127:80] != 0 || q > lim) q = lim;
                    q = entered[0] ? q : -q;
                    if (n == 0) f.fx = q[31:0];
                    else if (n == 1) f.fy = q[31:0];
                    else f.fz = q[31:0];
                end
            end
            pending.push_back(f);
        endfunction

        function void check_force(logic [103:0] d);
            t_force got, exp;
            got.fx = d[31:0];
            got.fy = d[63:32];
            got.fz = d[95:64];
            got.wall = d[98:96];
            if (pending.size() == 0) begin
                $display("%0t unexpected force transaction %h", $time, d);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.fx !== exp.fx) begin
                $display("%0t force_x exp %h got %h", $time, exp.fx, got.fx);
                errors++;
            end
            if (got.fy !== exp.fy) begin
                $display("%0t force_y exp %h got %h", $time, exp.fy, got.fy);
                errors++;
            end
            if (got.fz !== exp.fz) begin
                $display("%0t force_z exp %h got %h", $time, exp.fz, got.fz);
                errors++;
            end
            if (got.wall !== exp.wall) begin
                $display("%0t contact_wall exp %0d got %0d", $time, exp.wall, got.wall);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [103:0] m_axis_tdata;
    logic i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    force_board board;
    int hold_off;
    bit stall_en;

    haptic_box_wall_force i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("tb_top: done, errors");
        $finish;
    end

    function int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 3);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        board.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_position({z, y, x});
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    function logic [31:0] near(logic [31:0] base, logic [31:0] span);
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0) return $urandom;
        return base + $urandom_range(0, 2 * span + 4) - 2 + ($urandom_range(0, 1) ? 0 : -span);
    endfunction

    task automatic box_phase(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] g, logic [31:0] r, int count);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_CZ, cz);
        write_reg(REG_SX, sx);
        write_reg(REG_SY, sy);
        write_reg(REG_SZ, sz);
        write_reg(REG_GAIN, g);
        write_reg(REG_RAD, r);
        for (int i = 0; i < count; i++) begin
            send_pos(near(cx, sx[30:0] + r[30:0]), near(cy, sy[30:0] + r[30:0]),
                     near(cz, sz[30:0] + r[30:0]), 1);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && i_rst_n) board.check_force(m_axis_tdata);
    end

    initial begin
        int g;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off > 0) begin
                m_axis_tready <= 0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            g = stall_en ? pick_gap() : 0;
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
        end
    end

    initial begin
        board = new();
        board.clear();
        hold_off = 0;
        stall_en = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset box (all zero), extremes of the position fields
        send_pos(0, 0, 0, 0);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        drain();
        write_reg(REG_SX, 32'h0004_0000);
        write_reg(REG_SY, 32'h0004_0000);
        write_reg(REG_SZ, 32'h0004_0000);
        write_reg(REG_GAIN, 32'h0010_0000);
        write_reg(REG_RAD, 32'h0001_0000);
        // each face in contact, sticky then release
        send_pos(32'h0000_8000, 32'h0002_0000, 32'h0002_0000, 0);
        send_pos(32'h0003_8000, 32'h0002_0000, 32'h0002_0000, 0);
        send_pos(32'h0002_0000, 32'h0000_8000, 32'h0002_0000, 0);
        send_pos(32'h0002_0000, 32'h0003_8000, 32'h0002_0000, 0);
        send_pos(32'h0002_0000, 32'h0002_0000, 32'h0000_8000, 0);
        send_pos(32'h0002_0000, 32'h0002_0000, 32'h0003_8000, 0);
        send_pos(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0);
        send_pos(32'hFFFF_8000, 32'h0002_0000, 32'h0002_0000, 0);
        // edge and corner, needing the root
        send_pos(32'hFFFF_C000, 32'hFFFF_C000, 32'h0002_0000, 0);
        send_pos(32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_C000, 0);
        send_pos(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 0);
        send_pos(32'h00FF_0000, 32'h0002_0000, 32'h0002_0000, 0);
        drain();
        // saturation, both signs
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_RAD, 32'h7FFF_FFFF);
        send_pos(32'h0000_8000, 32'h0002_0000, 32'h0002_0000, 0);
        send_pos(32'h0003_8000, 32'h0002_0000, 32'h0002_0000, 0);
        drain();

        stall_en = 1;
        box_phase(32'hFFF0_0000, 32'h0010_0000, 32'h0, 32'h0020_0000, 32'h0008_0000,
                  32'h0010_0000, 32'h0001_0000, 32'h0002_0000, 150);
        box_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 60);
        box_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
                  32'h0000_8000, 32'h0000_4000, 60);
        // receiver holds off while positions keep coming
        hold_off = 300;
        box_phase($urandom, $urandom, $urandom, $urandom_range(0, 32'h0040_0000),
                  $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                  $urandom, $urandom_range(0, 32'h0010_0000), 150);
        box_phase($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 80);
        box_phase(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0100_0000, 32'h0000_1000,
                  32'h0100_0000, 32'h0000_0000, 80);

        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
